[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL. They expect signals named
// clk and rst in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define LRS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Checked at every edge, reset included
`define LRS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

[rtl/lrs_pkg.sv]
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared constants, tables, state encodings and interface structs for the
// rolling regression slope block.
// ----------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

  // Window store geometry
  localparam int MAX_PERIOD = 64;
  localparam int PTR_W      = $clog2(MAX_PERIOD);
  localparam int CNT_W      = $clog2(MAX_PERIOD + 1);

  // Field widths
  localparam int SAMPLE_W   = 32;
  localparam int PERIOD_W   = 7;
  localparam int PERIOD_RST = 20;

  // Arithmetic widths, sized for MAX_PERIOD = 64
  localparam int SUM_Y_W    = 40;
  localparam int SUM_XY_W   = 46;
  localparam int NUM_W      = 54;
  localparam int SX_W       = 11;
  localparam int DEN_W      = 21;
  localparam int QUO_W      = 32;

  typedef logic [SX_W-1:0]  sx_tab_t  [0:MAX_PERIOD];
  typedef logic [DEN_W-1:0] den_tab_t [0:MAX_PERIOD];

  // sum of x over a window of n: n(n-1)/2
  function automatic sx_tab_t sx_table();
    sx_tab_t t;
    longint  n;
    for (int i = 0; i <= MAX_PERIOD; i++) begin
      n    = longint'(i);
      t[i] = SX_W'((n * (n - 1)) / 2);
    end
    return t;
  endfunction

  // n*SXX - SX*SX = n^2 (n^2 - 1) / 12
  function automatic den_tab_t den_table();
    den_tab_t t;
    longint   n;
    for (int i = 0; i <= MAX_PERIOD; i++) begin
      n    = longint'(i);
      t[i] = DEN_W'((n * n * (n * n - 1)) / 12);
    end
    return t;
  endfunction

  localparam sx_tab_t  SX_TAB  = sx_table();
  localparam den_tab_t DEN_TAB = den_table();

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_MULT,
    ST_NUM,
    ST_DIV,
    ST_PUT
  } seq_state_t;

  // Divider states
  typedef enum logic [2:0] {
    DV_IDLE,
    DV_ABS,
    DV_ROUND,
    DV_CHECK,
    DV_RUN,
    DV_DONE
  } div_state_t;

  // Divider request and response
  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] slope;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/lrs_sample_ram.sv]
// ----------------------------------------------------------------------------
// lrs_sample_ram
// Circular sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_sample_ram
  import lrs_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [PTR_W-1:0]           wr_addr,
  input  wire logic signed [SAMPLE_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [PTR_W-1:0]           rd_addr,
  output logic signed [SAMPLE_W-1:0]      rd_data
);

  logic signed [SAMPLE_W-1:0] mem [0:MAX_PERIOD-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/lrs_divider.sv]
// ----------------------------------------------------------------------------
// lrs_divider
// Signed numerator over positive denominator, rounded half away from zero,
// saturated to 32 bits. Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_divider
  import lrs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int HI_W = NUM_W - QUO_W;

  div_state_t state;
  div_state_t state_next;

  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        dvd;
  logic [DEN_W-1:0]        den;
  logic                    neg;
  logic                    sat;
  logic [DEN_W-1:0]        rem;
  logic [QUO_W-1:0]        lo;
  logic [QUO_W-1:0]        quo;
  logic [4:0]              cnt;

  logic [DEN_W:0]          trial;
  logic                    trial_ge;
  logic                    hi_ge;
  logic [QUO_W:0]          qv;
  logic [QUO_W:0]          qc;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE:  if (req.start) state_next = DV_ABS;
      DV_ABS:   state_next = DV_ROUND;
      DV_ROUND: state_next = DV_CHECK;
      DV_CHECK: state_next = hi_ge ? DV_DONE : DV_RUN;
      DV_RUN:   if (cnt == 5'd31) state_next = DV_DONE;
      DV_DONE:  state_next = DV_IDLE;
      default:  state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Restoring step and overflow check
  assign trial    = {rem, lo[QUO_W-1]};
  assign trial_ge = (trial >= {1'b0, den});
  assign hi_ge    = ({1'b0, dvd[NUM_W-1:QUO_W]} >= (HI_W + 1)'(den));

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        num <= req.num;
        den <= req.den;
      end
      DV_ABS: begin
        neg <= num[NUM_W-1];
        dvd <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      end
      DV_ROUND: begin
        dvd <= dvd + NUM_W'(den >> 1);
      end
      DV_CHECK: begin
        sat <= hi_ge;
        rem <= DEN_W'(dvd[NUM_W-1:QUO_W]);
        lo  <= dvd[QUO_W-1:0];
        cnt <= '0;
      end
      DV_RUN: begin
        rem <= trial_ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        lo  <= {lo[QUO_W-2:0], 1'b0};
        quo <= {quo[QUO_W-2:0], trial_ge};
        cnt <= cnt + 5'd1;
      end
      default: ;
    endcase
  end

  // Saturate and apply sign
  always_comb begin
    qv = sat ? {1'b1, {QUO_W{1'b0}}} : {1'b0, quo};
    if (neg) begin
      qc = (qv > {2'b01, {(QUO_W-1){1'b0}}}) ? {2'b01, {(QUO_W-1){1'b0}}} : qv;
    end else begin
      qc = (qv > {2'b00, {(QUO_W-1){1'b1}}}) ? {2'b00, {(QUO_W-1){1'b1}}} : qv;
    end
  end

  // Outputs
  always_comb begin
    rsp.done  = (state == DV_DONE);
    rsp.slope = neg ? -$signed(qc[QUO_W-1:0]) : $signed(qc[QUO_W-1:0]);
  end

endmodule

`default_nettype wire

[rtl/rolling_linreg_slope.sv]
// ----------------------------------------------------------------------------
// rolling_linreg_slope
// Least-squares slope over the latest window of Q16.16 price samples.
//
// Channels: s_* takes one sample per beat (tdata = close_price, tuser =
// restart_series). m_* gives one result per sample (tdata = slope, then
// window_used; tuser = slope_valid). cfg_* writes window_period at any
// time the block is idle; cfg_ready is always high.
// Each sample is written into a 64-entry store; the window of W samples is
// then read back one entry per cycle to form the sums, two products give the
// numerator and a one-bit-per-cycle divider gives the rounded slope.
// One sample is in work at a time, so no new sample is accepted until the
// current result has moved from the sequencer into the output register.
// The output register lets the next sample be taken while a result waits;
// if the receiver stalls, a finished result holds in the sequencer until the
// output register frees.
// Reset clears the series (count and pointer) and sets window_period to 20.
// Store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rolling_linreg_slope
  import lrs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // config write
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [PERIOD_W-1:0] cfg_data,   // window_period
  // sample input
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [31:0]         s_tdata,    // [31:0] close_price
  input  wire logic [0:0]          s_tuser,    // [0] restart_series
  // result output
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [39:0]              m_tdata,    // [31:0] slope, [38:32] window_used
  output logic [0:0]               m_tuser     // [0] slope_valid
);

  seq_state_t state;
  seq_state_t state_next;

  logic [PERIOD_W-1:0] period;
  logic [PTR_W-1:0]    wp;
  logic [CNT_W-1:0]    count;

  logic [CNT_W-1:0]    win_w;
  logic [PTR_W-1:0]    win_start;
  logic [CNT_W-1:0]    rd_idx;
  logic                rd_pend;
  logic [PTR_W-1:0]    rd_idx_d;

  logic signed [SUM_Y_W-1:0]  sum_y;
  logic signed [SUM_XY_W-1:0] sum_xy;
  logic signed [NUM_W-1:0]    prod_a;
  logic signed [NUM_W-1:0]    prod_b;

  logic signed [SAMPLE_W-1:0] res_slope;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_slope;
  logic [CNT_W-1:0]           out_w;
  logic                       out_sv;

  logic                       in_fire;
  logic                       rd_en;
  logic                       put_fire;
  logic                       read_done;

  logic [PERIOD_W-1:0]        per_clamp;
  logic [CNT_W-1:0]           w_calc;
  logic [PTR_W-1:0]           base_wp;
  logic [CNT_W-1:0]           base_cnt;

  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W+PTR_W:0] xy_term;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_W'(PERIOD_RST);
    end else if (cfg_valid && cfg_ready) begin
      period <= cfg_data;
    end
  end

  // -------------------------------------------------------- sequencer: next
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_fire) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_READ;
      ST_READ:  if (read_done) state_next = ST_MULT;
      ST_MULT:  state_next = ST_NUM;
      ST_NUM:   state_next = div_req.start ? ST_DIV : ST_PUT;
      ST_DIV:   if (div_rsp.done) state_next = ST_PUT;
      ST_PUT:   if (put_fire) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ----------------------------------------------------- sequencer: outputs
  always_comb begin
    s_tready      = (state == ST_IDLE);
    rd_en         = (state == ST_READ) && (rd_idx < win_w);
    read_done     = (rd_idx == win_w) && !rd_pend;
    put_fire      = (state == ST_PUT) && (!out_valid || m_tready);
  end

  assign in_fire = s_tvalid && s_tready;

  // ------------------------------------------------------ series bookkeeping
  assign base_wp  = s_tuser[0] ? '0 : wp;
  assign base_cnt = s_tuser[0] ? '0 : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      count <= '0;
    end else if (in_fire) begin
      wp    <= base_wp + PTR_W'(1);
      count <= (base_cnt == CNT_W'(MAX_PERIOD)) ? base_cnt : base_cnt + CNT_W'(1);
    end
  end

  // window length: min(clamped period, count)
  always_comb begin
    if (period == '0) begin
      per_clamp = PERIOD_W'(1);
    end else if (period > PERIOD_W'(MAX_PERIOD)) begin
      per_clamp = PERIOD_W'(MAX_PERIOD);
    end else begin
      per_clamp = period;
    end
    w_calc = (CNT_W'(per_clamp) < count) ? CNT_W'(per_clamp) : count;
  end

  // ----------------------------------------------------------- sample store
  lrs_sample_ram u_ram (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (base_wp),
    .wr_data (s_tdata),
    .rd_en   (rd_en),
    .rd_addr (win_start + rd_idx[PTR_W-1:0]),
    .rd_data (rd_data)
  );

  // --------------------------------------------------- read sweep and sums
  assign xy_term = (SAMPLE_W + PTR_W + 1)'($signed({1'b0, rd_idx_d}))
                 * (SAMPLE_W + PTR_W + 1)'(rd_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      win_w     <= w_calc;
      win_start <= wp - w_calc[PTR_W-1:0];
      rd_idx    <= '0;
      sum_y     <= '0;
      sum_xy    <= '0;
    end else begin
      if (rd_en) begin
        rd_idx   <= rd_idx + CNT_W'(1);
        rd_idx_d <= rd_idx[PTR_W-1:0];
      end
      if (rd_pend) begin
        sum_y  <= sum_y + SUM_Y_W'(rd_data);
        sum_xy <= sum_xy + SUM_XY_W'(xy_term);
      end
    end
  end

  // ------------------------------------------------------------- numerator
  // operands widened first so the products keep their full range
  always_ff @(posedge clk) begin
    if (state == ST_MULT) begin
      prod_a <= NUM_W'($signed({1'b0, win_w})) * NUM_W'(sum_xy);
      prod_b <= NUM_W'($signed({1'b0, SX_TAB[win_w]})) * NUM_W'(sum_y);
    end
  end

  assign div_req.start = (state == ST_NUM) && (win_w >= CNT_W'(2));
  assign div_req.num   = prod_a - prod_b;
  assign div_req.den   = DEN_TAB[win_w];

  lrs_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (state == ST_NUM && !div_req.start) begin
      res_slope <= '0;
    end else if (div_rsp.done) begin
      res_slope <= div_rsp.slope;
    end
  end

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_fire) begin
      out_slope <= res_slope;
      out_w     <= win_w;
      out_sv    <= (win_w >= CNT_W'(2));
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_w, out_slope};
  assign m_tuser  = out_sv;

  // ------------------------------------------------------------ assertions
  `LRS_ASSERT_ALWAYS(a_rst_clears_series, $past(rst) |-> (count == '0 && wp == '0))
  `LRS_ASSERT(a_window_in_count, (state == ST_READ) |-> (win_w != '0 && win_w <= count))
  `LRS_ASSERT(a_sweep_bounded, (state == ST_READ) |-> (rd_idx <= win_w))
  `LRS_ASSERT(a_div_done_in_div, div_rsp.done |-> (state == ST_DIV))
  `LRS_ASSERT(a_valid_matches_w, out_valid |-> (out_sv == (out_w >= CNT_W'(2))))

endmodule

`default_nettype wire

[sim/tb_rolling_linreg_slope.sv]
// ----------------------------------------------------------------------------
// tb_rolling_linreg_slope
// Self-checking testbench for the rolling regression slope block.
// Samples are streamed in under random sender and receiver stalls. A scoreboard
// keeps its own window of samples and works out the rounded, saturated slope,
// window size and valid flag for each accepted beat. Every result beat is
// compared field by field. Window period settings cover the clamped values
// below and above the legal range.
// ----------------------------------------------------------------------------
module tb_rolling_linreg_slope
  import lrs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 150;

  // one expected result beat
  typedef struct {
    logic [31:0]         slope;
    logic [PERIOD_W-1:0] used;
    logic                valid;
  } slope_beat_t;

  // Scoreboard: own copy of the sample store and window setting
  class slope_predictor;
    slope_beat_t         pending_slopes[$];
    int                  samples_store[MAX_PERIOD];
    int                  wr_ptr;
    int                  fill;
    logic [PERIOD_W-1:0] period;
    int                  errors;
    int                  samples_in;
    int                  results_out;
    int                  not_valid_seen;
    int                  saturated_seen;
    int                  periods_written;

    function new();
      wr_ptr          = 0;
      fill            = 0;
      period          = PERIOD_W'(PERIOD_RST);
      errors          = 0;
      samples_in      = 0;
      results_out     = 0;
      not_valid_seen  = 0;
      saturated_seen  = 0;
      periods_written = 0;
    endfunction

    function void set_period(logic [PERIOD_W-1:0] value);
      period = value;
      periods_written++;
    endfunction

    // Append a sample and predict the slope over the current window
    function void take_sample(logic [31:0] price, logic restart);
      int                  p;
      int                  w;
      int                  first;
      longint              sum_y;
      longint              sum_xy;
      longint              sx;
      longint              den;
      longint              num;
      longint unsigned     mag;
      longint unsigned     q;
      slope_beat_t         r;
      if (restart) begin
        wr_ptr = 0;
        fill   = 0;
      end
      samples_store[wr_ptr] = price;
      wr_ptr = (wr_ptr + 1) % MAX_PERIOD;
      if (fill < MAX_PERIOD) fill++;
      p = int'(period);
      if (p < 1) p = 1;
      if (p > MAX_PERIOD) p = MAX_PERIOD;
      w = (p < fill) ? p : fill;
      first = (wr_ptr + MAX_PERIOD - w) % MAX_PERIOD;
      sum_y  = 0;
      sum_xy = 0;
      for (int i = 0; i < w; i++) begin
        sum_y  += longint'(samples_store[(first + i) % MAX_PERIOD]);
        sum_xy += longint'(i) * longint'(samples_store[(first + i) % MAX_PERIOD]);
      end
      r.slope = '0;
      r.used  = PERIOD_W'(w);
      r.valid = 1'b0;
      if (w >= 2) begin
        sx  = longint'(w) * (w - 1) / 2;
        den = longint'(w) * w * (longint'(w) * w - 1) / 12;
        if (den != 0) begin
          num = longint'(w) * sum_xy - sx * sum_y;
          mag = (num < 0) ? longint'(-num) : num;
          // round half away from zero
          q = (mag + longint'(den / 2)) / longint'(den);
          if (num < 0) begin
            if (q > 64'h8000_0000) begin
              q = 64'h8000_0000;
              saturated_seen++;
            end
            r.slope = ~q[31:0] + 32'd1;
          end else begin
            if (q > 64'h7FFF_FFFF) begin
              q = 64'h7FFF_FFFF;
              saturated_seen++;
            end
            r.slope = q[31:0];
          end
          r.valid = 1'b1;
        end
      end
      if (!r.valid) not_valid_seen++;
      samples_in++;
      pending_slopes.push_back(r);
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(logic [39:0] data, logic [0:0] user);
      slope_beat_t r;
      results_out++;
      if (pending_slopes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual slope %h used %0d valid %b",
                 $time, data[31:0], data[38:32], user[0]);
        return;
      end
      r = pending_slopes.pop_front();
      if (data[31:0] !== r.slope) begin
        errors++;
        $display("%0t: slope expected %h actual %h", $time, r.slope, data[31:0]);
      end
      if (data[38:32] !== r.used) begin
        errors++;
        $display("%0t: window_used expected %0d actual %0d", $time, r.used, data[38:32]);
      end
      if (user[0] !== r.valid) begin
        errors++;
        $display("%0t: slope_valid expected %b actual %b", $time, r.valid, user[0]);
      end
    endfunction

    function int outstanding();
      return pending_slopes.size();
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [PERIOD_W-1:0] cfg_data  = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata   = '0;   // [31:0] close_price
  logic [0:0]          s_tuser   = '0;   // [0] restart_series
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [39:0]         m_tdata;          // [31:0] slope, [38:32] window_used
  logic [0:0]          m_tuser;          // [0] slope_valid

  slope_predictor slopes = new();

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          idle_cycles   = 0;
  logic [31:0] last_price    = '0;

  rolling_linreg_slope DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else     m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Beat monitors
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) slopes.set_period(cfg_data);
      if (s_tvalid && s_tready)   slopes.take_sample(s_tdata, s_tuser[0]);
      if (m_tvalid && m_tready)   slopes.check_result(m_tdata, m_tuser);
    end
  end

  // Watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // One sample beat; valid stays high for a back-to-back beat
  task automatic send_sample(input logic [31:0] price, input logic restart);
    // sender idles cycle by cycle with the current probability
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= price;
    s_tuser  <= restart;
    do @(posedge clk); while (!s_tready);
    last_price = price;
  endtask

  // Hold off the sender until every result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (slopes.outstanding() != 0);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly a random walk, with full-range noise and extremes mixed in
  function automatic logic [31:0] next_price();
    int kind;
    kind = $urandom_range(9);
    case (kind)
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return last_price + 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
    endcase
  endfunction

  int unsigned seg_periods[12] = '{64, 5, 2, 127, 33, 1, 64, 0, 65, 17, 2, 40};

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default window, short series, restarts, both saturation limits
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h0002_0000, 1'b0);
    send_sample(32'h0003_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h1234_5678, 1'b0);
    send_sample(32'hEDCB_A987, 1'b0);
    drain_results();
    // two-sample window: slope is the plain difference
    write_period(PERIOD_W'(2));
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    drain_results();
    // single-sample window never gives a valid slope
    write_period(PERIOD_W'(1));
    send_sample(32'h0005_0000, 1'b0);
    send_sample(32'h0009_0000, 1'b0);
    drain_results();
    // out-of-range periods clamp to 1 and to the store depth
    write_period(PERIOD_W'(0));
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    drain_results();
    write_period(PERIOD_W'(127));
    send_sample(32'h4000_0000, 1'b0);
    send_sample(32'hC000_0000, 1'b0);
    drain_results();

    // Random segments: stall profile changes every four segments
    for (int seg = 0; seg < 12; seg++) begin
      case (seg / 4)
        0: begin send_idle_pct = 19; recv_idle_pct = 81; end
        1: begin send_idle_pct = 81; recv_idle_pct = 19; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_period((seg == 11) ? PERIOD_W'($urandom_range(1, MAX_PERIOD))
                               : PERIOD_W'(seg_periods[seg]));
      for (int n = 0; n < 80; n++) begin
        send_sample(next_price(), ($urandom_range(49) == 0));
        if ($urandom_range(99) == 0) drain_results();
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (slopes.outstanding() != 0) begin
      slopes.errors++;
      $display("%0t: %0d results never arrived", $time, slopes.outstanding());
    end
    $display("Run covered %0d samples and %0d result beats over %0d window settings.",
             slopes.samples_in, slopes.results_out, slopes.periods_written);
    $display("Results without a valid slope: %0d, saturated slopes: %0d.",
             slopes.not_valid_seen, slopes.saturated_seen);
    if (slopes.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
